// File: sv/icdf_pkg.sv
// ----------------------------------------------------------------------------
// icdf_pkg: shared types and constants for the inverse-CDF table sampler
// Function codes, status codes, the lookup mode constant and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package icdf_pkg;

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_APPEND = 2'd1,
      FUNC_SAMPLE = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_NOT_ASC = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   localparam logic MODE_INTERP = 1'b0;

   typedef enum logic [4:0] {
      S_IDLE,
      S_APPEND,
      S_APPEND_HI,
      S_MUL_HI,
      S_MUL_LO,
      S_TARGET,
      S_SRCH_REQ,
      S_SRCH_CMP,
      S_FETCH,
      S_FETCH_WAIT,
      S_SEG,
      S_DIV,
      S_SPAN_MUL,
      S_FINISH,
      S_OUT
   } state_type;

endpackage
`default_nettype wire

// File: sv/inverse_cdf_table_sampler.sv
// ----------------------------------------------------------------------------
// inverse_cdf_table_sampler: tabulated inverse-CDF sampler
// Builds running cumulative sums of a loaded table and draws samples by
// scaled uniform target, binary search and, in interpolated mode, linear interpolation.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)                      | tuser
//  req     | in  | x_value[31:0] weight[47:32] uniform[79:48]    | func
//  rsp     | out | sample_x[31:0] sample_index[39:32]            | status
//  csr     | in  | lookup_mode (write enable + data, no read-back)
//
//  Clear and unused codes go straight to hand-off; an append checks and
//  writes the new sum, and in interpolated mode writes sum[c] as well. A
//  sample scales the uniform target, runs a binary search of at most 8
//  steps at N=256 over the sum memory through one read port and, in
//  interpolated mode, adds two fetches, the segment step, a 32-step
//  restoring divider, a multiply and an add. One item is in work at a time;
//  req_tready is high only in idle. The result waits in a register until
//  rsp_tready. Reset is synchronous and clears control state only; the
//  memories hold undefined data until written.
// ----------------------------------------------------------------------------
`default_nettype none
module inverse_cdf_table_sampler #(
   parameter int MAX_ENTRIES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,   // x_value, weight, uniform
   input  wire logic [1:0]  req_tuser,   // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // sample_x, sample_index
   output logic [1:0]       rsp_tuser,   // status
   input  wire logic        csr_we,
   input  wire logic        csr_wdata
);

   localparam int AW = $clog2(MAX_ENTRIES + 1);   // sum memory index width
   localparam int XW = $clog2(MAX_ENTRIES);       // abscissa index width
   localparam int CW = $clog2(MAX_ENTRIES + 1);   // count width

   // memories
   logic [31:0] xmem [MAX_ENTRIES];
   logic [63:0] cmem [MAX_ENTRIES + 1];
   logic [63:0] crd_ff;
   logic [31:0] xrd_ff;

   logic          c_we, x_we;
   logic [AW-1:0] c_wa, c_ra;
   logic [63:0]   c_wd;
   logic [XW-1:0] x_wa, x_ra;
   logic [31:0]   x_wd;

   always_ff @(posedge clock) begin
      if (c_we) cmem[c_wa] <= c_wd;
      crd_ff <= cmem[c_ra];
   end
   always_ff @(posedge clock) begin
      if (x_we) xmem[x_wa] <= x_wd;
      xrd_ff <= xmem[x_ra];
   end

   icdf_pkg::state_type  state_ff, state_in;
   logic              mode_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [63:0]       total_ff, total_in;
   logic [31:0]       lastx_ff, lastx_in;
   logic [15:0]       lastw_ff, lastw_in;
   logic [1:0]        func_ff, func_in;
   logic [31:0]       xv_ff, xv_in;
   logic [15:0]       w_ff, w_in;
   logic [31:0]       u_ff, u_in;
   logic [63:0]       prod_ff, prod_in;
   logic [63:0]       tgt_ff, tgt_in;
   logic [CW-1:0]     lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [63:0]       ca_ff, ca_in, rem_ff, rem_in, dd_ff, dd_in;
   logic [31:0]       xa_ff, xa_in, q_ff, q_in;
   logic [5:0]        k_ff, k_in;
   logic              phase_ff, phase_in;
   logic [31:0]       sx_ff, sx_in;
   logic [7:0]        si_ff, si_in;
   logic [1:0]        st_ff, st_in;
   logic              rv_ff, rv_in;

   logic [32:0] dxw;
   logic [63:0] dx_ext, rsh;
   logic [64:0] rsh2;
   logic [CW:0] midsum;
   logic        interp;

   assign interp = (mode_ff == icdf_pkg::MODE_INTERP);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= icdf_pkg::S_IDLE;
         mode_ff  <= 1'b0;
         count_ff <= '0;
         total_ff <= '0;
         lastx_ff <= '0;
         lastw_ff <= '0;
         phase_ff <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) mode_ff <= csr_wdata;
         count_ff <= count_in;
         total_ff <= total_in;
         lastx_ff <= lastx_in;
         lastw_ff <= lastw_in;
         phase_ff <= phase_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in; xv_ff <= xv_in; w_ff <= w_in; u_ff <= u_in;
      prod_ff <= prod_in; tgt_ff <= tgt_in;
      lo_ff <= lo_in; hi_ff <= hi_in; mid_ff <= mid_in;
      ca_ff <= ca_in; rem_ff <= rem_in; dd_ff <= dd_in;
      xa_ff <= xa_in; q_ff <= q_in; k_ff <= k_in;
      sx_ff <= sx_in; si_ff <= si_in; st_ff <= st_in;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff; total_in = total_ff;
      lastx_in = lastx_ff; lastw_in = lastw_ff;
      func_in = func_ff; xv_in = xv_ff; w_in = w_ff; u_in = u_ff;
      prod_in = prod_ff; tgt_in = tgt_ff;
      lo_in = lo_ff; hi_in = hi_ff; mid_in = mid_ff;
      ca_in = ca_ff; rem_in = rem_ff; dd_in = dd_ff;
      xa_in = xa_ff; q_in = q_ff; k_in = k_ff; phase_in = phase_ff;
      sx_in = sx_ff; si_in = si_ff; st_in = st_ff; rv_in = rv_ff;
      c_we = 1'b0; c_wa = '0; c_wd = total_ff;
      x_we = 1'b0; x_wa = count_ff[XW-1:0]; x_wd = xv_ff;
      c_ra = mid_ff[AW-1:0];
      x_ra = mid_ff[XW-1:0];
      req_tready = 1'b0;
      dxw    = {xv_ff[31], xv_ff} - {lastx_ff[31], lastx_ff};
      dx_ext = {32'd0, dxw[31:0]};
      rsh    = '0;
      rsh2   = '0;
      midsum = {1'b0, lo_ff} + {1'b0, hi_ff} + {{CW{1'b0}}, 1'b1};
      if (rv_ff && rsp_tready) rv_in = 1'b0;

      case (state_ff)
         icdf_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               func_in = req_tuser;
               xv_in = req_tdata[31:0];
               w_in  = req_tdata[47:32];
               u_in  = req_tdata[79:48];
               sx_in = '0; si_in = '0; st_in = icdf_pkg::ST_OK;
               case (icdf_pkg::func_type'(req_tuser))
                  icdf_pkg::FUNC_CLEAR: begin
                     count_in = '0; total_in = '0; lastx_in = '0; lastw_in = '0;
                     state_in = icdf_pkg::S_OUT;
                  end
                  icdf_pkg::FUNC_APPEND: state_in = icdf_pkg::S_APPEND;
                  icdf_pkg::FUNC_SAMPLE: state_in = icdf_pkg::S_MUL_HI;
                  default: state_in = icdf_pkg::S_OUT;
               endcase
            end
         end
         icdf_pkg::S_APPEND: begin
            // phase 0: checks and the product (trapezoid in interpolated mode); phase 1: new total
            // into sum[c+1]; interpolated mode then writes sum[c] as well
            if (!phase_ff) begin
               if (count_ff >= CW'(MAX_ENTRIES)) begin
                  st_in = icdf_pkg::ST_FULL; state_in = icdf_pkg::S_OUT;
               end else if (interp && count_ff != '0 &&
                            $signed(xv_ff) < $signed(lastx_ff)) begin
                  st_in = icdf_pkg::ST_NOT_ASC; state_in = icdf_pkg::S_OUT;
               end else begin
                  if (interp && count_ff != '0)
                     prod_in = dx_ext * {47'd0, {1'b0, lastw_ff} + {1'b0, w_ff}};
                  else if (interp)
                     prod_in = '0;
                  else
                     prod_in = {48'd0, w_ff};
                  // first entry: sum[0] = 0
                  if (count_ff == '0) begin
                     c_we = 1'b1; c_wa = '0; c_wd = 64'd0;
                  end
                  x_we = 1'b1;
                  phase_in = 1'b1;
               end
            end else begin
               total_in = total_ff + prod_ff;
               c_we = 1'b1; c_wa = AW'(count_ff + 1'b1); c_wd = total_ff + prod_ff;
               lastx_in = xv_ff; lastw_in = w_ff;
               count_in = count_ff + 1'b1;
               phase_in = 1'b0;
               state_in = interp ? icdf_pkg::S_APPEND_HI : icdf_pkg::S_OUT;
            end
         end
         icdf_pkg::S_APPEND_HI: begin
            // count already bumped: sum[count-1] = new total
            c_we = 1'b1; c_wa = AW'(count_ff - 1'b1); c_wd = total_ff;
            state_in = icdf_pkg::S_OUT;
         end
         icdf_pkg::S_MUL_HI: begin
            if (total_ff == '0 || count_ff < (interp ? CW'(2) : CW'(1))) begin
               st_in = icdf_pkg::ST_EMPTY; state_in = icdf_pkg::S_OUT;
            end else begin
               prod_in = {32'd0, u_ff} * {32'd0, total_ff[63:32]};
               state_in = icdf_pkg::S_MUL_LO;
            end
         end
         icdf_pkg::S_MUL_LO: begin
            tgt_in  = prod_ff;
            prod_in = {32'd0, u_ff} * {32'd0, total_ff[31:0]};
            state_in = icdf_pkg::S_TARGET;
         end
         icdf_pkg::S_TARGET: begin
            tgt_in = tgt_ff + {32'd0, prod_ff[63:32]};
            lo_in = '0;
            hi_in = interp ? count_ff - CW'(2) : count_ff - CW'(1);
            state_in = icdf_pkg::S_SRCH_REQ;
         end
         icdf_pkg::S_SRCH_REQ: begin
            if (lo_ff < hi_ff) begin
               mid_in = midsum[CW:1];
               state_in = icdf_pkg::S_SRCH_CMP;
            end else begin
               mid_in = lo_ff;
               si_in = 8'(lo_ff);
               state_in = interp ? icdf_pkg::S_FETCH : icdf_pkg::S_OUT;
            end
         end
         icdf_pkg::S_SRCH_CMP: begin
            // phase 1: the read of cum[mid] issued last cycle is in crd_ff now
            if (phase_ff) begin
               if (crd_ff <= tgt_ff) lo_in = mid_ff;
               else hi_in = mid_ff - 1'b1;
               phase_in = 1'b0;
               state_in = icdf_pkg::S_SRCH_REQ;
            end else phase_in = 1'b1;
         end
         icdf_pkg::S_FETCH: begin
            // mid holds j; read cum[j], x[j]
            mid_in = mid_ff + 1'b1;
            state_in = icdf_pkg::S_FETCH_WAIT;
         end
         icdf_pkg::S_FETCH_WAIT: begin
            ca_in = crd_ff; xa_in = xrd_ff;
            state_in = icdf_pkg::S_SEG;
         end
         icdf_pkg::S_SEG: begin
            // cum[j+1], x[j+1] arrive
            rem_in = tgt_ff - ca_ff;
            dd_in  = (crd_ff > ca_ff) ? crd_ff - ca_ff : 64'd0;
            xa_in  = xa_ff;
            sx_in  = xrd_ff - xa_ff;   // span parked here
            q_in = '0; k_in = '0;
            state_in = icdf_pkg::S_DIV;
         end
         icdf_pkg::S_DIV: begin
            if (k_ff == 6'd0 && dd_ff == '0) begin
               q_in = '0; state_in = icdf_pkg::S_SPAN_MUL;
            end else if (k_ff == 6'd0 && rem_ff >= dd_ff) begin
               q_in = '1; state_in = icdf_pkg::S_SPAN_MUL;
            end else begin
               rsh2 = {rem_ff, 1'b0};
               if (rsh2 >= {1'b0, dd_ff}) begin
                  rsh = 64'(rsh2 - {1'b0, dd_ff});
                  q_in = {q_ff[30:0], 1'b1};
               end else begin
                  rsh = rsh2[63:0];
                  q_in = {q_ff[30:0], 1'b0};
               end
               rem_in = rsh;
               k_in = k_ff + 1'b1;
               if (k_ff == 6'd31) state_in = icdf_pkg::S_SPAN_MUL;
            end
         end
         icdf_pkg::S_SPAN_MUL: begin
            prod_in = {32'd0, q_ff} * {32'd0, sx_ff};
            state_in = icdf_pkg::S_FINISH;
         end
         icdf_pkg::S_FINISH: begin
            sx_in = xa_ff + prod_ff[63:32];
            state_in = icdf_pkg::S_OUT;
         end
         icdf_pkg::S_OUT: begin
            if (!rv_ff || rsp_tready) begin
               rv_in = 1'b1;
               state_in = icdf_pkg::S_IDLE;
            end
         end
         default: state_in = icdf_pkg::S_IDLE;
      endcase
   end

   assign rsp_tvalid = rv_ff;
   logic [31:0] osx_ff;
   logic [7:0]  osi_ff;
   logic [1:0]  ost_ff;
   always_ff @(posedge clock) begin
      if (state_ff == icdf_pkg::S_OUT && (!rv_ff || rsp_tready)) begin
         osx_ff <= sx_ff; osi_ff <= si_ff; ost_ff <= st_ff;
      end
   end
   assign rsp_tdata = {osi_ff, osx_ff};
   assign rsp_tuser = ost_ff;

   // the result register is loaded only from the hand-off state
   a_load: assert property (@(posedge clock) disable iff (reset)
      (!$past(rv_ff) && rv_ff) |-> $past(state_ff) == icdf_pkg::S_OUT)
      else $error("result valid without hand-off");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES)) else $error("entry count overflow");
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == icdf_pkg::S_IDLE)
      else $error("ready outside idle");
   a_srch: assert property (@(posedge clock) disable iff (reset)
      state_ff == icdf_pkg::S_SRCH_CMP |-> lo_ff < hi_ff)
      else $error("search bounds crossed");

endmodule
`default_nettype wire
